### src/qsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsc_pkg
// Shared types and constants for the quicksort unit: payload structs, the
// controller-to-datapath command set and the datapath status bundle.
// ----------------------------------------------------------------------------
package qsc_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 11;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     final_item;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic [CNT_W-1:0]         comparisons;
    logic                     final_result;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_POP,
    OP_RANGE,
    OP_KEY,
    OP_SCAN,
    OP_SWAP1,
    OP_SWAP2,
    OP_FIN_RD,
    OP_FIN_W1,
    OP_FIN_W2,
    OP_PUSH_R,
    OP_PUSH_L,
    OP_EMIT,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic fill_ge2;
    logic sp_zero;
    logic le;
    logic i_last;
    logic emit_last;
  } status_t;

endpackage

### src/quicksort_with_comparison_count_unit.sv
`timescale 1ns / 1ps
// A non-final request is stored; a final request starts the sort.
// Results then leave one per cycle; N results.
// Throughput is bounded by the single store read port: quadratic worst case in N.
// Reset (rst, synchronous) empties the store and stack and clears the count;
// stored values are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// quicksort_with_comparison_count_unit
// Collects signed values, sorts them by quicksort with first-element pivot,
// and returns them ascending with the total pivot comparison count.
// ----------------------------------------------------------------------------
module quicksort_with_comparison_count_unit import qsc_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  item,
  output logic      busy,
  output out_item_t result,
  output logic      done
);

  cmd_t    cmd;
  status_t status;

  qsc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .final_item (item.final_item),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  qsc_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .status (status),
    .result (result),
    .done   (done)
  );

endmodule

### src/qsc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsc_ram
// Generic RAM with one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module qsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/qsc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsc_datapath
// Element store, range stack, partition registers and comparison counter.
// Executes one command from the controller per cycle.
// ----------------------------------------------------------------------------
module qsc_datapath import qsc_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  in_item_t  item,
  output status_t   status,
  output out_item_t result,
  output logic      done
);

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = 2 * IW;
  localparam logic [CW-1:0] FILL_MAX = CW'(MAX_ITEMS);

  logic [CW-1:0]            fill;
  logic [CW-1:0]            sp;
  logic [CW-1:0]            k;
  logic [IW-1:0]            lo;
  logic [IW-1:0]            hi;
  logic [IW-1:0]            i;
  logic [IW-1:0]            mid;
  logic signed [DATA_W-1:0] key;
  logic [DATA_W-1:0]        a;
  logic [CNT_W-1:0]         count;
  logic                     emit_pend;
  logic                     emit_last;

  logic              st_we;
  logic [IW-1:0]     st_waddr;
  logic [DATA_W-1:0] st_wdata;
  logic              st_re;
  logic [IW-1:0]     st_raddr;
  logic [DATA_W-1:0] st_rdata;

  logic          sk_we;
  logic [IW-1:0] sk_waddr;
  logic [SW-1:0] sk_wdata;
  logic          sk_re;
  logic [IW-1:0] sk_raddr;
  logic [SW-1:0] sk_rdata;

  logic [IW-1:0] mid_inc;
  logic [IW-1:0] i_inc;
  logic [IW:0]   mid_ext1;
  logic [IW:0]   lo_ext1;
  logic [CW-1:0] fill_m1;
  logic [CW-1:0] sp_m1;
  logic [CW-1:0] k_inc;
  logic [IW-1:0] lo_r;
  logic [IW-1:0] hi_r;
  logic          le;
  logic          i_last;
  logic          room;
  logic          push_r_ok;
  logic          push_l_ok;

  qsc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_store (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (st_wdata),
    .rd_en   (st_re),
    .rd_addr (st_raddr),
    .rd_data (st_rdata)
  );

  qsc_ram #(.WIDTH(SW), .DEPTH(MAX_ITEMS)) u_stack (
    .clk     (clk),
    .wr_en   (sk_we),
    .wr_addr (sk_waddr),
    .wr_data (sk_wdata),
    .rd_en   (sk_re),
    .rd_addr (sk_raddr),
    .rd_data (sk_rdata)
  );

  assign mid_inc   = mid + IW'(1);
  assign i_inc     = i + IW'(1);
  assign mid_ext1  = {1'b0, mid} + (IW+1)'(1);
  assign lo_ext1   = {1'b0, lo} + (IW+1)'(1);
  assign fill_m1   = fill - CW'(1);
  assign sp_m1     = sp - CW'(1);
  assign k_inc     = k + CW'(1);
  assign lo_r      = sk_rdata[SW-1:IW];
  assign hi_r      = sk_rdata[IW-1:0];
  assign le        = $signed(st_rdata) <= key;
  assign i_last    = (i == hi);
  assign room      = (sp < FILL_MAX);
  // right part holds more than one element and the stack has room
  assign push_r_ok = (mid_ext1 < {1'b0, hi}) && room;
  // left part holds more than one element and the stack has room
  assign push_l_ok = ({1'b0, mid} > lo_ext1) && room;

  assign status.fill_ge2  = (fill >= CW'(2));
  assign status.sp_zero   = (sp == '0);
  assign status.le        = le;
  assign status.i_last    = i_last;
  assign status.emit_last = (k_inc == fill);

  always_comb begin
    st_we    = 1'b0;
    st_waddr = '0;
    st_wdata = '0;
    st_re    = 1'b0;
    st_raddr = '0;
    sk_we    = 1'b0;
    sk_waddr = '0;
    sk_wdata = '0;
    sk_re    = 1'b0;
    sk_raddr = '0;
    case (cmd.op)
      OP_LOAD: begin
        if (fill < FILL_MAX) begin
          st_we    = 1'b1;
          st_waddr = fill[IW-1:0];
          st_wdata = item.value;
        end
      end
      OP_INIT: begin
        if (status.fill_ge2) begin
          sk_we    = 1'b1;
          sk_waddr = '0;
          sk_wdata = {IW'(0), fill_m1[IW-1:0]};
        end
      end
      OP_POP: begin
        sk_re    = 1'b1;
        sk_raddr = sp_m1[IW-1:0];
      end
      OP_RANGE: begin
        st_re    = 1'b1;
        st_raddr = lo_r;
      end
      OP_KEY: begin
        st_re    = 1'b1;
        st_raddr = i;
      end
      OP_SCAN: begin
        if (le) begin
          st_re    = 1'b1;
          st_raddr = mid_inc;
        end else if (!i_last) begin
          st_re    = 1'b1;
          st_raddr = i_inc;
        end
      end
      OP_SWAP1: begin
        st_we    = 1'b1;
        st_waddr = mid;
        st_wdata = a;
      end
      OP_SWAP2: begin
        // read data still holds the element displaced from mid
        st_we    = 1'b1;
        st_waddr = i;
        st_wdata = st_rdata;
        if (!i_last) begin
          st_re    = 1'b1;
          st_raddr = i_inc;
        end
      end
      OP_FIN_RD: begin
        st_re    = 1'b1;
        st_raddr = mid;
      end
      OP_FIN_W1: begin
        st_we    = 1'b1;
        st_waddr = lo;
        st_wdata = st_rdata;
      end
      OP_FIN_W2: begin
        st_we    = 1'b1;
        st_waddr = mid;
        st_wdata = key;
      end
      OP_PUSH_R: begin
        if (push_r_ok) begin
          sk_we    = 1'b1;
          sk_waddr = sp[IW-1:0];
          sk_wdata = {mid_ext1[IW-1:0], hi};
        end
      end
      OP_PUSH_L: begin
        if (push_l_ok) begin
          sk_we    = 1'b1;
          sk_waddr = sp[IW-1:0];
          sk_wdata = {lo, mid - IW'(1)};
        end
      end
      OP_EMIT: begin
        st_re    = 1'b1;
        st_raddr = k[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      sp        <= '0;
      k         <= '0;
      count     <= '0;
      emit_pend <= 1'b0;
      done      <= 1'b0;
    end else begin
      emit_pend <= (cmd.op == OP_EMIT);
      done      <= emit_pend;
      case (cmd.op)
        OP_LOAD: begin
          if (fill < FILL_MAX) begin
            fill <= fill + CW'(1);
          end
        end
        OP_INIT: begin
          count <= '0;
          k     <= '0;
          sp    <= status.fill_ge2 ? CW'(1) : '0;
        end
        OP_POP: begin
          sp <= sp_m1;
        end
        OP_RANGE: begin
          lo  <= lo_r;
          hi  <= hi_r;
          mid <= lo_r;
          i   <= lo_r + IW'(1);
        end
        OP_KEY: begin
          key <= st_rdata;
        end
        OP_SCAN: begin
          if (count != CNT_MAX) begin
            count <= count + CNT_W'(1);
          end
          if (le) begin
            a   <= st_rdata;
            mid <= mid_inc;
          end else if (!i_last) begin
            i <= i_inc;
          end
        end
        OP_SWAP2: begin
          if (!i_last) begin
            i <= i_inc;
          end
        end
        OP_PUSH_R: begin
          if (push_r_ok) begin
            sp <= sp + CW'(1);
          end
        end
        OP_PUSH_L: begin
          if (push_l_ok) begin
            sp <= sp + CW'(1);
          end
        end
        OP_EMIT: begin
          k <= k_inc;
        end
        OP_CLEAR: begin
          fill <= '0;
          sp   <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // result register, loaded in the cycle after the store read
  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      emit_last <= status.emit_last;
    end
    if (emit_pend) begin
      result.sorted_value <= st_rdata;
      result.comparisons  <= count;
      result.final_result <= emit_last;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_MAX)
    else $error("fill count beyond store depth");

  a_scan_window: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_SCAN |-> (i > lo) && (i <= hi) && (mid < i))
    else $error("scan index outside partition range");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    (count == CNT_MAX) && (cmd.op != OP_INIT) |=> count == CNT_MAX)
    else $error("comparison count wrapped");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    done && result.final_result |-> (fill == '0) && (sp == '0))
    else $error("store not emptied after last result");

endmodule

### src/qsc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsc_ctrl
// Sequencer for load, partition, range stack handling and result readout.
// ----------------------------------------------------------------------------
module qsc_ctrl import qsc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    final_item,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_POP,
    ST_RANGE,
    ST_KEY,
    ST_SCAN,
    ST_SWAP1,
    ST_SWAP2,
    ST_FIN_RD,
    ST_FIN_W1,
    ST_FIN_W2,
    ST_PUSH_R,
    ST_PUSH_L,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          if (final_item) begin
            state_next = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd.op     = OP_INIT;
        state_next = status.fill_ge2 ? ST_POP : ST_EMIT;
      end
      ST_POP: begin
        if (status.sp_zero) begin
          state_next = ST_EMIT;
        end else begin
          cmd.op     = OP_POP;
          state_next = ST_RANGE;
        end
      end
      ST_RANGE: begin
        cmd.op     = OP_RANGE;
        state_next = ST_KEY;
      end
      ST_KEY: begin
        cmd.op     = OP_KEY;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.op = OP_SCAN;
        if (status.le) begin
          state_next = ST_SWAP1;
        end else if (status.i_last) begin
          state_next = ST_FIN_RD;
        end
      end
      ST_SWAP1: begin
        cmd.op     = OP_SWAP1;
        state_next = ST_SWAP2;
      end
      ST_SWAP2: begin
        cmd.op     = OP_SWAP2;
        state_next = status.i_last ? ST_FIN_RD : ST_SCAN;
      end
      ST_FIN_RD: begin
        cmd.op     = OP_FIN_RD;
        state_next = ST_FIN_W1;
      end
      ST_FIN_W1: begin
        cmd.op     = OP_FIN_W1;
        state_next = ST_FIN_W2;
      end
      ST_FIN_W2: begin
        cmd.op     = OP_FIN_W2;
        state_next = ST_PUSH_R;
      end
      ST_PUSH_R: begin
        cmd.op     = OP_PUSH_R;
        state_next = ST_PUSH_L;
      end
      ST_PUSH_L: begin
        cmd.op     = OP_PUSH_L;
        state_next = ST_POP;
      end
      ST_EMIT: begin
        cmd.op = OP_EMIT;
        if (status.emit_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.op     = OP_CLEAR;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

endmodule

### tb/qsc_sort_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsc_sort_checker
// Watches the request and result channels of the quicksort unit, keeps its own
// copy of the held values, sorts them with first-element pivot partitioning
// when the final request is taken, and compares every result strobe against
// the oldest predicted value, comparison count and last flag.
// ----------------------------------------------------------------------------
module qsc_sort_checker import qsc_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  item,
  input  logic      done,
  input  out_item_t result,
  output int        failures,
  output int        outstanding
);

  logic signed [DATA_W-1:0] held [MAX_ITEMS];
  int                       held_count;
  logic [CNT_W-1:0]         pivot_compares;
  out_item_t                expected_sorted[$];
  int                       mismatch_count = 0;

  assign failures = mismatch_count;

  // partition one range around its first element, return the pivot slot
  function automatic int split_held(int lo, int hi);
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] tmp;
    int                       mid;
    key = held[lo];
    mid = lo;
    for (int i = lo + 1; i <= hi; i++) begin
      if (held[i] <= key) begin
        mid++;
        tmp       = held[mid];
        held[mid] = held[i];
        held[i]   = tmp;
      end
      if (pivot_compares != CNT_MAX) pivot_compares++;
    end
    held[lo]  = held[mid];
    held[mid] = key;
    return mid;
  endfunction

  function automatic void sort_held_values();
    int range_lo [MAX_ITEMS];
    int range_hi [MAX_ITEMS];
    int depth;
    int lo;
    int hi;
    int mid;
    pivot_compares = '0;
    depth = 0;
    if (held_count >= 2) begin
      range_lo[0] = 0;
      range_hi[0] = held_count - 1;
      depth = 1;
    end
    while (depth > 0) begin
      depth--;
      lo  = range_lo[depth];
      hi  = range_hi[depth];
      mid = split_held(lo, hi);
      // right part goes under the left part on the stack
      if (mid + 1 < hi && depth < MAX_ITEMS) begin
        range_lo[depth] = mid + 1;
        range_hi[depth] = hi;
        depth++;
      end
      if (mid > lo && lo < mid - 1 && depth < MAX_ITEMS) begin
        range_lo[depth] = lo;
        range_hi[depth] = mid - 1;
        depth++;
      end
    end
  endfunction

  function automatic void take_request(in_item_t req);
    out_item_t exp_item;
    if (held_count < MAX_ITEMS) begin
      held[held_count] = req.value;
      held_count++;
    end
    if (req.final_item) begin
      sort_held_values();
      for (int k = 0; k < held_count; k++) begin
        exp_item.sorted_value = held[k];
        exp_item.comparisons  = pivot_compares;
        exp_item.final_result = (k == held_count - 1);
        expected_sorted.push_back(exp_item);
      end
      held_count = 0;
    end
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t exp_item;
    logic      bad;
    if (expected_sorted.size() == 0) begin
      $error("unexpected result: sorted_value %0d", got.sorted_value);
      mismatch_count++;
    end else begin
      exp_item = expected_sorted.pop_front();
      bad = 1'b0;
      if (got.sorted_value !== exp_item.sorted_value) begin
        $error("sorted_value: expected %0d, got %0d", exp_item.sorted_value, got.sorted_value);
        bad = 1'b1;
      end
      if (got.comparisons !== exp_item.comparisons) begin
        $error("comparisons: expected %0d, got %0d", exp_item.comparisons, got.comparisons);
        bad = 1'b1;
      end
      if (got.final_result !== exp_item.final_result) begin
        $error("final_result: expected %0d, got %0d", exp_item.final_result,
               got.final_result);
        bad = 1'b1;
      end
      if (bad) mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held_count     = 0;
      pivot_compares = '0;
      expected_sorted.delete();
    end else begin
      if (done) check_result(result);
      if (start && !busy) take_request(item);
    end
    outstanding <= expected_sorted.size();
  end

endmodule

### tb/tb_quicksort_with_comparison_count_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quicksort_with_comparison_count_unit
// Feeds sequences of signed values to the quicksort unit: a directed set of
// edge cases, then random sequences of varied shape and length, including one
// that overfills the store, with the sender idling at varying rates.
// ----------------------------------------------------------------------------
module tb_quicksort_with_comparison_count_unit;
  import qsc_pkg::*;

  localparam int MAX_ITEMS = 64;
  localparam int ITEM_TARGET = 220;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef enum int {SEQ_MIXED, SEQ_DUPS, SEQ_RISING, SEQ_FALLING, SEQ_FLAT} seq_shape_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  in_item_t  item = '0;
  logic      busy;
  logic      done;
  out_item_t result;
  int        failures;
  int        outstanding;

  int        idle_pct = 0;
  int        sent = 0;
  logic signed [DATA_W-1:0] seq_vals[$];

  always #5 clk = ~clk;

  quicksort_with_comparison_count_unit #(.MAX_ITEMS(MAX_ITEMS)) u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .result (result),
    .done   (done)
  );

  qsc_sort_checker #(.MAX_ITEMS(MAX_ITEMS)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .done        (done),
    .result      (result),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic signed [DATA_W-1:0] pick_value(int flavor);
    case (flavor)
      0: pick_value = $urandom;
      1: pick_value = $urandom_range(8) - 4;
      default: begin
        case ($urandom_range(5))
          0: pick_value = VAL_MIN;
          1: pick_value = VAL_MAX;
          2: pick_value = 0;
          3: pick_value = -1;
          4: pick_value = VAL_MIN + 1;
          default: pick_value = VAL_MAX - 1;
        endcase
      end
    endcase
  endfunction

  function automatic void build_sequence(int len, seq_shape_t shape);
    logic signed [DATA_W-1:0] flat_val;
    seq_vals.delete();
    flat_val = pick_value($urandom_range(2));
    for (int k = 0; k < len; k++) begin
      case (shape)
        SEQ_DUPS: seq_vals.push_back(pick_value(1));
        SEQ_FLAT: seq_vals.push_back(flat_val);
        default:  seq_vals.push_back(pick_value($urandom_range(3) == 0 ? 2 : 0));
      endcase
    end
    if (shape == SEQ_RISING) seq_vals.sort();
    if (shape == SEQ_FALLING) seq_vals.rsort();
  endfunction

  task automatic send_request(logic signed [DATA_W-1:0] value, logic last);
    int       gap;
    in_item_t req;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.value      = value;
    req.final_item = last;
    start <= 1'b1;
    item  <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic send_sequence();
    for (int k = 0; k < seq_vals.size(); k++)
      send_request(seq_vals[k], k == seq_vals.size() - 1);
  endtask

  // hold the sender off until every predicted result has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int len;
    int waited;
    bit full_done;
    full_done = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single element, two extremes, mixed extremes, duplicates, falling, single element
    idle_pct = 24;
    seq_vals = '{VAL_MIN};
    send_sequence();
    seq_vals = '{VAL_MAX, VAL_MIN};
    send_sequence();
    seq_vals = '{0, -1, 1, VAL_MAX, VAL_MIN, VAL_MAX - 1, VAL_MIN + 1};
    send_sequence();
    seq_vals = '{5, 5, 5, -5, 5};
    send_sequence();
    seq_vals = '{4, 3, 2, 1, 0, -1};
    send_sequence();
    seq_vals = '{32'sh5555_5555};
    send_sequence();
    wait_drained();

    while (sent < ITEM_TARGET) begin
      if (sent < 80) begin
        idle_pct = 24;
      end else if (sent < 160) begin
        if (idle_pct != 76) wait_drained();
        idle_pct = 76;
      end else begin
        if (idle_pct != 0) wait_drained();
        idle_pct = 0;
      end
      if (idle_pct == 76 && !full_done) begin
        // sorted full store gives the most comparisons; extra values are dropped
        build_sequence(MAX_ITEMS, SEQ_RISING);
        repeat (3) seq_vals.push_back(pick_value(0));
        full_done = 1'b1;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        build_sequence(len, seq_shape_t'($urandom_range(4)));
      end
      send_sequence();
    end

    start <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (outstanding != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (outstanding != 0) $error("results never arrived: %0d", outstanding);
    if (failures == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
